/* rtl/hps_pkg.sv */
// Shared constants, payload types and state codes for the shifted Halton point block.
package hps_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int INDEX_BITS = 32;
  localparam int RADIX_BITS = 8;
  localparam int NUM_BITS   = INDEX_BITS + RADIX_BITS;

  localparam int DIG_CELLS  = 4;
  localparam int FRAC_CELLS = 2;
  localparam int IDX_PAD    = ((INDEX_BITS + DIG_CELLS - 1) / DIG_CELLS) * DIG_CELLS;
  localparam int FRAC_PAD   = ((FRAC_BITS + FRAC_CELLS - 1) / FRAC_CELLS) * FRAC_CELLS;
  localparam int DIG_STEPS  = IDX_PAD / DIG_CELLS;
  localparam int FRAC_STEPS = FRAC_PAD / FRAC_CELLS;
  localparam int MAX_STEPS  = (DIG_STEPS > FRAC_STEPS) ? DIG_STEPS : FRAC_STEPS;
  localparam int CNT_BITS   = $clog2(MAX_STEPS + 1);

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [RADIX_BITS-1:0] MIN_RADIX   = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RESET_BASE_X = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RESET_BASE_Y = RADIX_BITS'(3);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE_X = 2'd0,
    REG_BASE_Y = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DIV,
    C_ACC,
    C_FRAC,
    C_DONE
  } coord_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } hps_status_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] sample_index;
    logic [FRAC_BITS-1:0]  offset_u;
    logic [FRAC_BITS-1:0]  offset_v;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] point_x;
    logic [FRAC_BITS-1:0] point_y;
  } out_item_t;

endpackage

/* rtl/hps_step_cell.sv */
// One restoring division step: shift in a bit, subtract the divisor when it fits.
module hps_step_cell #(
  parameter int W = 8
) (
  input  logic [W-1:0] rem_in,
  input  logic         bit_in,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] rem_out,
  output logic         qbit
);

  logic [W:0] trial;
  logic [W:0] diff;

  assign trial   = {rem_in, bit_in};
  assign diff    = trial - {1'b0, divisor};
  assign qbit    = (trial >= {1'b0, divisor});
  assign rem_out = qbit ? diff[W-1:0] : trial[W-1:0];

endmodule

/* rtl/hps_coord.sv */
// One coordinate: digit extraction, reversed-digit accumulation, fraction division, shift.
module hps_coord (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hps_pkg::INDEX_BITS-1:0] sample_index,
  input  logic [hps_pkg::FRAC_BITS-1:0]  offset,
  input  logic [hps_pkg::RADIX_BITS-1:0] radix,
  input  logic                          ack,
  output hps_pkg::hps_status_t          status,
  output logic [hps_pkg::FRAC_BITS-1:0]  point
);

  localparam int IB = hps_pkg::INDEX_BITS;
  localparam int FB = hps_pkg::FRAC_BITS;
  localparam int RB = hps_pkg::RADIX_BITS;
  localparam int NB = hps_pkg::NUM_BITS;
  localparam int DC = hps_pkg::DIG_CELLS;
  localparam int FC = hps_pkg::FRAC_CELLS;
  localparam int IP = hps_pkg::IDX_PAD;
  localparam int FP = hps_pkg::FRAC_PAD;
  localparam int CB = hps_pkg::CNT_BITS;

  hps_pkg::coord_state_t state, state_next;

  logic [CB-1:0] cnt;
  logic [IP-1:0] sh;
  logic [RB-1:0] digit;
  logic [RB-1:0] radix_r;
  logic [NB-1:0] num;
  logic [NB-1:0] den;
  logic [NB-1:0] r;
  logic [FP-1:0] q;
  logic [FB-1:0] offset_r;

  // digit division chain
  logic [RB-1:0] dig_rem [DC+1];
  logic [DC-1:0] dig_q;
  // fraction division chain
  logic [NB-1:0] frac_rem [FC+1];
  logic [FC-1:0] frac_q;

  logic [NB+RB-1:0] num_prod;
  logic [NB+RB-1:0] den_prod;
  logic [NB-1:0]    num_new;
  logic [FP-1:0]    q_next;

  assign dig_rem[0]  = digit;
  assign frac_rem[0] = r;

  for (genvar i = 0; i < DC; i++) begin : g_dig
    hps_step_cell #(.W(RB)) u_cell (
      .rem_in (dig_rem[i]),
      .bit_in (sh[IP-1-i]),
      .divisor(radix_r),
      .rem_out(dig_rem[i+1]),
      .qbit   (dig_q[DC-1-i])
    );
  end

  for (genvar i = 0; i < FC; i++) begin : g_frac
    hps_step_cell #(.W(NB)) u_cell (
      .rem_in (frac_rem[i]),
      .bit_in (1'b0),
      .divisor(den),
      .rem_out(frac_rem[i+1]),
      .qbit   (frac_q[FC-1-i])
    );
  end

  assign num_prod = num * radix_r;
  assign den_prod = den * radix_r;
  assign num_new  = num_prod[NB-1:0] + {{(NB-RB){1'b0}}, digit};
  assign q_next   = {q[FP-FC-1:0], frac_q};

  always_comb begin
    state_next = state;
    unique case (state)
      hps_pkg::C_IDLE: begin
        if (start) begin
          state_next = (sample_index == '0) ? hps_pkg::C_FRAC : hps_pkg::C_DIV;
        end
      end
      hps_pkg::C_DIV: begin
        if (cnt == CB'(hps_pkg::DIG_STEPS - 1)) begin
          state_next = hps_pkg::C_ACC;
        end
      end
      hps_pkg::C_ACC: begin
        state_next = (sh == '0) ? hps_pkg::C_FRAC : hps_pkg::C_DIV;
      end
      hps_pkg::C_FRAC: begin
        if (cnt == CB'(hps_pkg::FRAC_STEPS - 1)) begin
          state_next = hps_pkg::C_DONE;
        end
      end
      hps_pkg::C_DONE: begin
        if (ack) begin
          state_next = hps_pkg::C_IDLE;
        end
      end
      default: state_next = hps_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    status.idle = (state == hps_pkg::C_IDLE);
    status.done = (state == hps_pkg::C_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hps_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hps_pkg::C_IDLE: begin
        if (start) begin
          sh       <= IP'(sample_index);
          radix_r  <= radix;
          offset_r <= offset;
          num      <= '0;
          den      <= NB'(1);
          r        <= '0;
          q        <= '0;
          digit    <= '0;
          cnt      <= '0;
        end
      end
      hps_pkg::C_DIV: begin
        sh    <= {sh[IP-DC-1:0], dig_q};
        digit <= dig_rem[DC];
        cnt   <= cnt + CB'(1);
      end
      hps_pkg::C_ACC: begin
        // fold the digit in behind the radix point
        num   <= num_new;
        den   <= den_prod[NB-1:0];
        r     <= num_new;
        digit <= '0;
        cnt   <= '0;
      end
      hps_pkg::C_FRAC: begin
        r   <= frac_rem[FC];
        q   <= q_next;
        cnt <= cnt + CB'(1);
        if (cnt == CB'(hps_pkg::FRAC_STEPS - 1)) begin
          point <= q_next[FP-1 -: FB] + offset_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/halton_point_with_random_shift.sv */
// Top level of the shifted Halton point generator: channels, base registers, result register.
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries a sample index and two
//   0.24 offsets; a transfer happens when in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall / out_data) carries point_x and point_y;
//   a transfer happens when out_valid is high and out_stall is low.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes base_x
//   (index 0) and base_y (index 1); other indexes are dropped. Write only while idle.
// Timing:
//   The x and y units run side by side, one item at a time; the slower one sets
//   the pace. For each digit of the index in its base, a unit runs DIG_STEPS
//   division steps and one accumulate step; DIG_STEPS = 8 (four division cells per
//   cycle on a 32-bit index). It then runs FRAC_STEPS = 12 (two cells per cycle,
//   24 bits) fraction steps; an index of 0 goes straight to these. Both results
//   then load the result register together, and the next item is taken once the
//   result register has loaded.
// Reset: rst (synchronous) clears control and loads base_x = 2, base_y = 3.
// Stall:
//   A finished result waits in the output register; a new item is taken meanwhile,
//   and a second result holds in the units until the register frees up.
module halton_point_with_random_shift (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hps_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output hps_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hps_pkg::RADIX_BITS-1:0]     cfg_data
);

  logic [hps_pkg::RADIX_BITS-1:0] base_x;
  logic [hps_pkg::RADIX_BITS-1:0] base_y;
  logic [hps_pkg::RADIX_BITS-1:0] radix_x;
  logic [hps_pkg::RADIX_BITS-1:0] radix_y;
  logic [hps_pkg::FRAC_BITS-1:0]  point_x;
  logic [hps_pkg::FRAC_BITS-1:0]  point_y;
  hps_pkg::hps_status_t           stat_x;
  hps_pkg::hps_status_t           stat_y;
  logic                           start;
  logic                           take;

  // Config writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x <= hps_pkg::RESET_BASE_X;
      base_y <= hps_pkg::RESET_BASE_Y;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hps_pkg::REG_BASE_X: base_x <= cfg_data;
        hps_pkg::REG_BASE_Y: base_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturate a radix below two to two.
  assign radix_x = (base_x < hps_pkg::MIN_RADIX) ? hps_pkg::MIN_RADIX : base_x;
  assign radix_y = (base_y < hps_pkg::MIN_RADIX) ? hps_pkg::MIN_RADIX : base_y;

  // Take a new item only when both coordinate units are free.
  assign in_stall = !(stat_x.idle && stat_y.idle);
  assign start    = in_valid && !in_stall;

  // Move a finished pair into the output register when it is empty or draining.
  assign take = stat_x.done && stat_y.done && (!out_valid || !out_stall);

  hps_coord u_coord_x (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .sample_index(in_data.sample_index),
    .offset      (in_data.offset_u),
    .radix       (radix_x),
    .ack         (take),
    .status      (stat_x),
    .point       (point_x)
  );

  hps_coord u_coord_y (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .sample_index(in_data.sample_index),
    .offset      (in_data.offset_v),
    .radix       (radix_y),
    .ack         (take),
    .status      (stat_y),
    .point       (point_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.point_x <= point_x;
      out_data.point_y <= point_y;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Testbench for the shifted Halton point generator: directed and random traffic checked against a predictor.
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  hps_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hps_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [hps_pkg::RADIX_BITS-1:0] cfg_data = '0;

  halton_point_with_random_shift uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the base registers.
  logic [hps_pkg::RADIX_BITS-1:0] radix_x = hps_pkg::RESET_BASE_X;
  logic [hps_pkg::RADIX_BITS-1:0] radix_y = hps_pkg::RESET_BASE_Y;

  hps_pkg::in_item_t  pending_samples[$];
  hps_pkg::out_item_t expected_points[$];
  int errors = 0;
  bit hold_sender = 1'b0;
  bit quiet_mode = 1'b0;

  // Truncated 0.FRAC_BITS radical inverse of idx in radix rdx.
  function automatic logic [hps_pkg::FRAC_BITS-1:0] mirror_digits(
      logic [hps_pkg::INDEX_BITS-1:0] idx, logic [hps_pkg::RADIX_BITS-1:0] rdx);
    logic [63:0] num, den, rem, r, b;
    logic [hps_pkg::FRAC_BITS-1:0] q;
    num = 0;
    den = 1;
    rem = 64'(idx);
    q = '0;
    b = (rdx < hps_pkg::MIN_RADIX) ? 64'(hps_pkg::MIN_RADIX) : 64'(rdx);
    while (rem > 0) begin
      num = num * b + rem % b;
      den = den * b;
      rem = rem / b;
    end
    r = num;
    for (int k = 0; k < hps_pkg::FRAC_BITS; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic hps_pkg::out_item_t shifted_point(hps_pkg::in_item_t s);
    hps_pkg::out_item_t p;
    p.point_x = mirror_digits(s.sample_index, radix_x) + s.offset_u;
    p.point_y = mirror_digits(s.sample_index, radix_y) + s.offset_v;
    return p;
  endfunction

  // Driver: pop pending samples, with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_points.push_back(shifted_point(in_data));
      end
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0 && !hold_sender) begin
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer and vary the stall.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("result with no expectation: %h", out_data);
          errors++;
        end else begin
          hps_pkg::out_item_t e;
          e = expected_points.pop_front();
          if (e.point_x !== out_data.point_x) begin
            $error("point_x expected %h actual %h", e.point_x, out_data.point_x);
            errors++;
          end
          if (e.point_y !== out_data.point_y) begin
            $error("point_y expected %h actual %h", e.point_y, out_data.point_y);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_base(hps_pkg::cfg_reg_t which, logic [hps_pkg::RADIX_BITS-1:0] value);
    cfg_index <= which;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (which == hps_pkg::REG_BASE_X) radix_x = value;
    else radix_y = value;
  endtask

  task automatic add_sample(logic [31:0] idx, logic [23:0] u, logic [23:0] v);
    hps_pkg::in_item_t s;
    s.sample_index = idx;
    s.offset_u = u;
    s.offset_v = v;
    pending_samples.push_back(s);
  endtask

  task automatic add_random(int count);
    logic [31:0] idx;
    for (int i = 0; i < count; i++) begin
      // half the indexes small, half full width
      case ($urandom_range(0, 3))
        0: idx = $urandom_range(0, 20);
        1: idx = $urandom_range(0, 5000);
        default: idx = $urandom;
      endcase
      add_sample(idx, 24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    logic [hps_pkg::RADIX_BITS-1:0] bx, by;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero index, extremes, offsets wrapping
    add_sample(0, 24'h000000, 24'hFFFFFF);
    add_sample(0, 24'hABCDEF, 24'h123456);
    add_sample(1, 24'hFFFFFF, 24'hFFFFFF);
    add_sample(32'hFFFFFFFF, 24'h000000, 24'h000000);
    add_sample(32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_sample(32'h80000000, 24'h800000, 24'h7FFFFF);
    add_sample(32'h55555555, 24'h555555, 24'hAAAAAA);
    add_sample(32'hAAAAAAAA, 24'hAAAAAA, 24'h555555);
    for (int i = 2; i < 8; i++) add_sample(i, 24'd0, 24'd0);
    wait_drained();

    // random sets over several radix settings, extremes and below-two included
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin bx = 8'd255; by = 8'd254; end
        1: begin bx = 8'd0; by = 8'd1; end
        2: begin bx = 8'd2; by = 8'd255; end
        3: begin bx = 8'd7; by = 8'd10; end
        default: begin
          bx = 8'($urandom_range(0, 255));
          by = 8'($urandom_range(0, 255));
        end
      endcase
      write_base(hps_pkg::REG_BASE_X, bx);
      write_base(hps_pkg::REG_BASE_Y, by);
      // an out-of-range index must be dropped
      cfg_index <= 2'd3;
      cfg_data <= 8'($urandom);
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      if (phase == 7) quiet_mode = 1'b1;
      add_random(35);
      // hold the sender once until every result has come
      if (phase == 5) begin
        while (pending_samples.size() > 15) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_points.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      add_random(40);
      wait_drained();
    end
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

/* filelist.f */
rtl/hps_pkg.sv
rtl/hps_step_cell.sv
rtl/hps_coord.sv
rtl/halton_point_with_random_shift.sv
tb/sv/tb.sv
